### design/raft_follower_message_handler_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef RAFT_FOLLOWER_MESSAGE_HANDLER_UNIT_ASSERT_SVH
`define RAFT_FOLLOWER_MESSAGE_HANDLER_UNIT_ASSERT_SVH

// Consequent holds in the cycle after the antecedent.
`define RFMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define RFMH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### design/rfmh_pkg.sv
package rfmh_pkg;

    localparam int LOG_DEPTH    = 1024;
    localparam int IDX_W        = $clog2(LOG_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int TERM_W       = 31;
    localparam int NODE_ID_BITS = 8;
    localparam int SENDER_W     = 8;
    localparam int OUT_IDX_W    = 10;
    localparam int CMD_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_VOTE   = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_ENTRY  = 2'd2
    } t_cmd;

    typedef logic [TERM_W-1:0] t_term;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_term data;
    } t_log_wr;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_log_rd;

endpackage

### design/raft_follower_message_handler_unit.sv
// Raft follower message handler.
// Input channel: an item (vote request, append header or append entry item)
// is taken at a rising edge with start high and busy low. busy is high in
// the cycle after that edge, while the item is handled, so the block cannot
// take a new item before it is through with the last one.
// At the accepting edge the log memory is read (last entry for a vote
// request, previous entry for an append header); the next edge applies the
// update and, where the item produces a result, registers it.
// Result channel: o_valid is high for exactly one cycle, the cycle after
// the handling edge, and the result fields are valid in that cycle. The
// receiver cannot stall; a result is taken in the cycle it is shown.
// Entry items of an open append and headers that open one give no result;
// the last entry item closes the append with one result.
// Reset (synchronous, active low) clears term, vote, commit index and the
// append state and sets the log to a single entry of term 0; busy is high
// while reset is asserted, and no clearing pass runs.
module raft_follower_message_handler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rfmh_pkg::CMD_W-1:0]        i_command,
    input  logic [rfmh_pkg::TERM_W-1:0]       i_msg_term,
    input  logic [rfmh_pkg::SENDER_W-1:0]     i_sender_id,
    input  logic [rfmh_pkg::TERM_W-1:0]       i_log_index,
    input  logic [rfmh_pkg::TERM_W-1:0]       i_log_term,
    input  logic [rfmh_pkg::TERM_W-1:0]       i_leader_commit,
    input  logic                              i_no_entries,
    input  logic [rfmh_pkg::TERM_W-1:0]       i_entry_term,
    input  logic                              i_last_entry,
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic [rfmh_pkg::TERM_W-1:0]       o_current_term,
    output logic [rfmh_pkg::OUT_IDX_W-1:0]    o_commit_index,
    output logic [rfmh_pkg::OUT_IDX_W-1:0]    o_last_log_index,
    output logic                              o_restart_timer,
    output logic                              o_log_full
);
    import rfmh_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state r_state, n_state;

    // captured item
    t_cmd                    r_cmd;
    t_term                   r_term, r_lidx, r_lterm, r_lcommit, r_eterm;
    logic [NODE_ID_BITS-1:0] r_sender;
    logic                    r_none, r_last;
    logic                    r_term_lt, r_term_gt, r_lidx_ge_cnt, r_lidx_ge_last;
    logic                    r_lc_lt_lidx;

    // node state
    t_term                   r_node_term, n_node_term;
    logic                    r_vote_valid, n_vote_valid;
    logic [NODE_ID_BITS-1:0] r_vote_holder, n_vote_holder;
    t_cnt                    r_log_count, n_log_count;
    t_idx                    r_commit, n_commit;
    logic                    r_open, n_open;
    t_term                   r_held, n_held;
    logic                    r_overflow, n_overflow;

    // result flags
    logic r_valid, n_valid;
    logic r_acc, n_acc;
    logic r_rst_tmr, n_rst_tmr;
    logic r_full, n_full;

    logic    accept;
    t_idx    last_idx;
    t_term   rd_data;
    t_log_wr wr;
    t_log_rd rd;

    assign busy     = (r_state == S_EXEC) || !i_rst_n;
    assign accept   = start && !busy;
    assign last_idx = IDX_W'(r_log_count - CNT_W'(1));

    assign rd.en   = accept;
    assign rd.addr = (t_cmd'(i_command) == CMD_HEADER) ? i_log_index[IDX_W-1:0] : last_idx;

    rfmh_log_ram u_log_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    // compares against node state are done at accept; state is stable
    // until the handling edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd          <= t_cmd'(i_command);
            r_term         <= i_msg_term;
            r_sender       <= NODE_ID_BITS'(i_sender_id);
            r_lidx         <= i_log_index;
            r_lterm        <= i_log_term;
            r_lcommit      <= i_leader_commit;
            r_none         <= i_no_entries;
            r_eterm        <= i_entry_term;
            r_last         <= i_last_entry;
            r_term_lt      <= i_msg_term < r_node_term;
            r_term_gt      <= i_msg_term > r_node_term;
            r_lidx_ge_cnt  <= i_log_index >= TERM_W'(r_log_count);
            r_lidx_ge_last <= i_log_index >= TERM_W'(last_idx);
            r_lc_lt_lidx   <= i_leader_commit < i_log_index;
        end
    end

    always_comb begin
        logic vote_eff;
        logic fresh;
        t_cnt cnt_next;
        t_idx new_last;

        n_state       = r_state;
        n_node_term   = r_node_term;
        n_vote_valid  = r_vote_valid;
        n_vote_holder = r_vote_holder;
        n_log_count   = r_log_count;
        n_commit      = r_commit;
        n_open        = r_open;
        n_held        = r_held;
        n_overflow    = r_overflow;
        n_valid       = 1'b0;
        n_acc         = 1'b0;
        n_rst_tmr     = 1'b0;
        n_full        = 1'b0;
        wr            = '0;
        vote_eff      = 1'b0;
        fresh         = 1'b0;
        cnt_next      = r_log_count;
        new_last      = last_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_cmd)
                    CMD_VOTE: begin
                        n_valid = 1'b1;
                        if (!r_term_lt) begin
                            vote_eff = r_vote_valid && !r_term_gt;
                            if (r_term_gt) begin
                                n_node_term = r_term;
                                n_open      = 1'b0;
                            end
                            if (r_lterm != rd_data) begin
                                fresh = r_lterm > rd_data;
                            end else begin
                                fresh = r_lidx_ge_last;
                            end
                            if ((!vote_eff || r_vote_holder == r_sender) && fresh) begin
                                n_vote_valid  = 1'b1;
                                n_vote_holder = r_sender;
                                n_acc         = 1'b1;
                                n_rst_tmr     = 1'b1;
                            end else begin
                                n_vote_valid = vote_eff;
                            end
                        end
                    end
                    CMD_HEADER: begin
                        n_open = 1'b0;
                        if (r_term_lt) begin
                            n_valid = 1'b1;
                        end else begin
                            n_node_term  = r_term;
                            n_vote_valid = 1'b0;
                            if (r_lidx_ge_cnt || rd_data != r_lterm) begin
                                n_valid   = 1'b1;
                                n_rst_tmr = 1'b1;
                            end else begin
                                // cut the log after the previous entry
                                n_log_count = {1'b0, r_lidx[IDX_W-1:0]} + CNT_W'(1);
                                if (r_none) begin
                                    n_commit  = r_lc_lt_lidx ? r_lcommit[IDX_W-1:0]
                                                             : r_lidx[IDX_W-1:0];
                                    n_valid   = 1'b1;
                                    n_acc     = 1'b1;
                                    n_rst_tmr = 1'b1;
                                end else begin
                                    n_open     = 1'b1;
                                    n_held     = r_lcommit;
                                    n_overflow = 1'b0;
                                end
                            end
                        end
                    end
                    CMD_ENTRY: begin
                        if (r_open) begin
                            if (r_log_count < CNT_W'(LOG_DEPTH)) begin
                                wr.en    = 1'b1;
                                wr.addr  = r_log_count[IDX_W-1:0];
                                wr.data  = r_eterm;
                                cnt_next = r_log_count + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                            n_log_count = cnt_next;
                            if (r_last) begin
                                new_last = IDX_W'(cnt_next - CNT_W'(1));
                                n_open   = 1'b0;
                                n_commit = (r_held < TERM_W'(new_last)) ? r_held[IDX_W-1:0]
                                                                        : new_last;
                                n_valid  = 1'b1;
                                n_acc    = 1'b1;
                                n_full   = n_overflow;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_node_term   <= '0;
            r_vote_valid  <= 1'b0;
            r_vote_holder <= '0;
            r_log_count   <= CNT_W'(1);
            r_commit      <= '0;
            r_open        <= 1'b0;
            r_held        <= '0;
            r_overflow    <= 1'b0;
            r_valid       <= 1'b0;
            r_acc         <= 1'b0;
            r_rst_tmr     <= 1'b0;
            r_full        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_node_term   <= n_node_term;
            r_vote_valid  <= n_vote_valid;
            r_vote_holder <= n_vote_holder;
            r_log_count   <= n_log_count;
            r_commit      <= n_commit;
            r_open        <= n_open;
            r_held        <= n_held;
            r_overflow    <= n_overflow;
            r_valid       <= n_valid;
            r_acc         <= n_acc;
            r_rst_tmr     <= n_rst_tmr;
            r_full        <= n_full;
        end
    end

    assign o_valid          = r_valid;
    assign o_accepted       = r_acc;
    assign o_current_term   = r_node_term;
    assign o_commit_index   = OUT_IDX_W'(r_commit);
    assign o_last_log_index = OUT_IDX_W'(last_idx);
    assign o_restart_timer  = r_rst_tmr;
    assign o_log_full       = r_full;

endmodule

### design/rfmh_log_ram.sv
module rfmh_log_ram (
    input  logic             i_clk,
    input  rfmh_pkg::t_log_wr i_wr,
    input  rfmh_pkg::t_log_rd i_rd,
    output rfmh_pkg::t_term  o_rd_data
);
    import rfmh_pkg::*;

    t_term mem [LOG_DEPTH];
    t_term r_rd_data;
    logic  r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // entry 0 is never written and always reads as term 0
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
            r_rd_zero <= (i_rd.addr == '0);
        end
    end

    assign o_rd_data = r_rd_zero ? '0 : r_rd_data;

endmodule

### design/rfmh_checker.sv
`include "raft_follower_message_handler_unit_assert.svh"

module rfmh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_accepted,
    input logic o_log_full
);
    // an accepted item holds the block busy while it is handled, and busy then drops
    `RFMH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `RFMH_ASSERT_NEXT(a_busy_one_cycle, i_clk, i_rst_n, busy, !busy)
    // a result is never followed directly by another result
    `RFMH_ASSERT_NEXT(a_valid_spacing, i_clk, i_rst_n, o_valid, !o_valid)
    // dropped entries are only reported on a closing append result
    `RFMH_ASSERT_NOW(a_full_accepted, i_clk, i_rst_n, o_valid && o_log_full, o_accepted)

endmodule

bind raft_follower_message_handler_unit rfmh_checker u_rfmh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_accepted (o_accepted),
    .o_log_full (o_log_full)
);
